/* hw/rtl/dpg_pkg.sv */
// Shared constants for the detector pixel gain calibration unit.
// Holds default sizes, request and register codes and fixed-point limits.
// No dependencies.
package dpg_pkg;

    // default storage geometry
    localparam int CELLS_DEF       = 32;
    localparam int PIXELS_DEF      = 65536;
    localparam int GAIN_STAGES_DEF = 2;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    // configuration register indexes
    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 6;
    localparam logic [1:0]  CFG_BYPASS = 2'd0;
    localparam logic [1:0]  CFG_CELLS  = 2'd1;

    // reset values
    localparam logic [5:0]  CELLS_IN_USE_RST = 6'd32;

    // output saturation limits on the rounded product
    localparam logic signed [33:0] VMAX = 34'sd8388607;
    localparam logic signed [33:0] VMIN = -34'sd8388608;

    // rounding bias for Q.12 to Q.4
    localparam logic signed [33:0] RND_BIAS = 34'sd128;

endpackage

/* hw/rtl/detector_pixel_gain_calibration_unit.sv */
// Top level of the detector pixel gain calibration unit.
// Depends on dpg_pkg and dpg_ram (threshold store and calibration store).
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ---------------------------------------
//  request   in         i_valid / o_stall      req_type cell_req pixel gain_select ...
//  result    out        o_valid / i_stall      corrected_value gain_stage bad_mask status
//  config    in         i_cfg_we               i_cfg_idx i_cfg_data
//
// One transfer per cycle while the output is not stalled; a pixel result passes the
// stage 1, 2, 3 and 4 registers into the output register. The path runs through the threshold read,
// the calibration read that depends on it, the multiplier stage and rounding.
// Loads produce no result and leave a bubble. Reset clears valid bits and the
// config registers only; the stores are not cleared. When the output register
// holds a result and the consumer stalls, every stage and both RAM read ports hold.
module detector_pixel_gain_calibration_unit #(
    parameter int CELLS       = dpg_pkg::CELLS_DEF,
    parameter int PIXELS      = dpg_pkg::PIXELS_DEF,
    parameter int GAIN_STAGES = dpg_pkg::GAIN_STAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config port
    input  logic                           i_cfg_we,
    input  logic [dpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // request channel
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_req_type,
    input  logic [4:0]                     i_cell_req,
    input  logic [15:0]                    i_pixel,
    input  logic                           i_gain_select,
    input  logic signed [15:0]             i_adu_sample,
    input  logic [15:0]                    i_gain_word,
    input  logic signed [15:0]             i_offset_value,
    input  logic signed [15:0]             i_threshold_value,
    input  logic [15:0]                    i_rel_gain,
    input  logic                           i_bad_flag,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [23:0]             o_corrected_value,
    output logic                           o_gain_stage,
    output logic                           o_bad_mask,
    output logic                           o_status
);

    import dpg_pkg::*;

    localparam int CW   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PW   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int SW   = $clog2(GAIN_STAGES);
    localparam int TAW  = CW + PW;
    localparam int CAW  = SW + CW + PW;
    localparam int CALW = 33;   // {bad, gain, offset}

    // config registers
    logic       r_bypass;
    logic [5:0] r_cells_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bypass       <= 1'b0;
            r_cells_in_use <= CELLS_IN_USE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BYPASS: r_bypass       <= i_cfg_data[0];
                CFG_CELLS:  r_cells_in_use <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // global advance: everything freezes when the result register is stuck
    logic r_ov;
    logic adv;
    assign adv     = !(r_ov && i_stall);
    assign o_stall = !adv;

    logic take;
    assign take = i_valid && adv;

    // ---------------- stage 0: range checks, threshold store access
    logic [7:0]     cell8;
    logic           in_store;
    logic           oor;
    logic [TAW-1:0] taddr;

    assign cell8    = {3'b000, i_cell_req};
    assign in_store = (cell8 < 8'(CELLS)) && ({1'b0, i_pixel} < 17'(PIXELS));
    assign oor      = !in_store || ({1'b0, i_cell_req} >= r_cells_in_use);
    assign taddr    = {cell8[CW-1:0], i_pixel[PW-1:0]};

    logic [15:0] thr_rdata;

    dpg_ram #(
        .WIDTH (16),
        .DEPTH (2 ** TAW),
        .AW    (TAW)
    ) u_thr_ram (
        .i_clk   (i_clk),
        .i_we    (take && (i_req_type == REQ_LOAD) && in_store && i_gain_select),
        .i_waddr (taddr),
        .i_wdata (i_threshold_value),
        .i_re    (adv),
        .i_raddr (taddr),
        .o_rdata (thr_rdata)
    );

    // stage 1 registers
    logic                r_v1;
    logic                r1_req;
    logic                r1_store;
    logic                r1_oor;
    logic [TAW-1:0]      r1_taddr;
    logic                r1_gsel;
    logic signed [15:0]  r1_adu;
    logic [15:0]         r1_gword;
    logic [CALW-1:0]     r1_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_req   <= i_req_type;
            r1_store <= in_store;
            r1_oor   <= oor;
            r1_taddr <= taddr;
            r1_gsel  <= i_gain_select;
            r1_adu   <= i_adu_sample;
            r1_gword <= i_gain_word;
            r1_cal   <= {i_bad_flag, i_rel_gain, i_offset_value};
        end
    end

    // ---------------- stage 1: gain stage pick, calibration store access
    logic           stage1;
    logic [1:0]     rd_stage2;
    logic [1:0]     wr_stage2;
    logic [CAW-1:0] cal_raddr;
    logic [CAW-1:0] cal_waddr;
    logic [CALW-1:0] cal_rdata;

    assign stage1    = !r_bypass &&
                       ($signed({1'b0, r1_gword}) > $signed({thr_rdata[15], thr_rdata}));
    assign rd_stage2 = {1'b0, stage1};
    assign wr_stage2 = {1'b0, r1_gsel};
    assign cal_raddr = {rd_stage2[SW-1:0], r1_taddr};
    assign cal_waddr = {wr_stage2[SW-1:0], r1_taddr};

    // loads write here so reads and writes keep request order
    dpg_ram #(
        .WIDTH (CALW),
        .DEPTH (2 ** CAW),
        .AW    (CAW)
    ) u_cal_ram (
        .i_clk   (i_clk),
        .i_we    (adv && r_v1 && (r1_req == REQ_LOAD) && r1_store),
        .i_waddr (cal_waddr),
        .i_wdata (r1_cal),
        .i_re    (adv),
        .i_raddr (cal_raddr),
        .o_rdata (cal_rdata)
    );

    // stage 2 registers
    logic               r_v2;
    logic               r2_oor;
    logic               r2_stage;
    logic signed [15:0] r2_adu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1 && (r1_req == REQ_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_oor   <= r1_oor;
            r2_stage <= stage1;
            r2_adu   <= r1_adu;
        end
    end

    // ---------------- stage 2: offset subtract
    logic signed [15:0] cal_off;
    logic signed [16:0] diff;

    assign cal_off = cal_rdata[15:0];
    assign diff    = {r2_adu[15], r2_adu} - {cal_off[15], cal_off};

    logic               r_v3;
    logic               r3_oor;
    logic               r3_stage;
    logic               r3_bad;
    logic [15:0]        r3_gain;
    logic signed [16:0] r3_diff;
    logic signed [15:0] r3_adu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_oor   <= r2_oor;
            r3_stage <= r2_stage;
            r3_bad   <= cal_rdata[32];
            r3_gain  <= cal_rdata[31:16];
            r3_diff  <= diff;
            r3_adu   <= r2_adu;
        end
    end

    // ---------------- stage 3: gain multiply
    logic signed [33:0] prod;
    assign prod = r3_diff * $signed({1'b0, r3_gain});

    logic               r_v4;
    logic               r4_oor;
    logic               r4_stage;
    logic               r4_bad;
    logic signed [33:0] r4_prod;
    logic signed [16:0] r4_diff;
    logic signed [15:0] r4_adu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_oor   <= r3_oor;
            r4_stage <= r3_stage;
            r4_bad   <= r3_bad;
            r4_prod  <= prod;
            r4_diff  <= r3_diff;
            r4_adu   <= r3_adu;
        end
    end

    // ---------------- stage 4: round, saturate, select result
    logic signed [33:0] rnd;
    logic signed [23:0] gained;
    logic signed [23:0] n_value;
    logic               n_stage;
    logic               n_bad;
    logic               n_status;

    assign rnd = (r4_prod + RND_BIAS) >>> 8;

    always_comb begin
        if (rnd > VMAX) begin
            gained = VMAX[23:0];
        end else if (rnd < VMIN) begin
            gained = VMIN[23:0];
        end else begin
            gained = rnd[23:0];
        end
    end

    always_comb begin
        n_value  = gained;
        n_stage  = r4_stage;
        n_bad    = 1'b0;
        n_status = 1'b0;
        if (r4_oor) begin
            // pass-through of the raw sample
            n_value  = {{4{r4_adu[15]}}, r4_adu, 4'b0000};
            n_stage  = 1'b0;
            n_status = 1'b1;
        end else if (r4_bad) begin
            n_value = '0;
            n_bad   = 1'b1;
        end else if (r_bypass) begin
            n_value = {{3{r4_diff[16]}}, r4_diff, 4'b0000};
        end
    end

    // output register
    logic               r_o_stage;
    logic               r_o_bad;
    logic               r_o_status;
    logic signed [23:0] r_o_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_value  <= n_value;
            r_o_stage  <= n_stage;
            r_o_bad    <= n_bad;
            r_o_status <= n_status;
        end
    end

    assign o_valid           = r_ov;
    assign o_corrected_value = r_o_value;
    assign o_gain_stage      = r_o_stage;
    assign o_bad_mask        = r_o_bad;
    assign o_status          = r_o_status;

`ifndef SYNTH
    // a bad pixel always reports zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_mask) |-> (o_corrected_value == 24'sd0))
        else $error("bad pixel result is not zero");

    // pass-through never carries a stage or a bad mark
    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (!o_bad_mask && !o_gain_stage))
        else $error("pass-through result carries stage or bad mark");

    // a stalled result keeps the whole pipe frozen
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_v4) && $stable(r_v1)))
        else $error("pipeline moved during a stall");
`endif

endmodule

/* hw/rtl/dpg_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the calibration and threshold stores; no dependencies.
module dpg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* dv/dpg_calib_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the detector pixel gain calibration unit: mirrors the calibration
// stores and registers, predicts every pixel result and compares it on transfer.
// Depends on dpg_pkg.
module dpg_calib_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [dpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dpg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  logic                           o_stall,
    input  logic                           i_req_type,
    input  logic [4:0]                     i_cell_req,
    input  logic [15:0]                    i_pixel,
    input  logic                           i_gain_select,
    input  logic signed [15:0]             i_adu_sample,
    input  logic [15:0]                    i_gain_word,
    input  logic signed [15:0]             i_offset_value,
    input  logic signed [15:0]             i_threshold_value,
    input  logic [15:0]                    i_rel_gain,
    input  logic                           i_bad_flag,
    input  logic                           o_valid,
    input  logic                           i_stall,
    input  logic signed [23:0]             o_corrected_value,
    input  logic                           o_gain_stage,
    input  logic                           o_bad_mask,
    input  logic                           o_status,
    output int                             o_fail_count,
    output int                             o_pending
);
    import dpg_pkg::*;

    typedef struct packed {
        logic signed [23:0] value;
        logic               stage;
        logic               bad;
        logic               status;
    } t_calib_result;

    localparam int     REPORT_MAX = 10;
    localparam longint SAT_HI     = 64'sd8388607;
    localparam longint SAT_LO     = -64'sd8388608;

    // mirrored stores: calibration keyed by {stage, cell, pixel}, threshold by {cell, pixel}
    logic [15:0] offset_mem [int];
    logic [15:0] gain_mem   [int];
    bit          bad_mem    [int];
    logic [15:0] thresh_mem [int];

    bit            bypass_q;
    logic [5:0]    cells_q;
    t_calib_result awaited_q [$];
    t_calib_result want;
    int            mismatches = 0;
    int            k;

    function automatic int slot_key(logic stage, logic [4:0] cell_idx, logic [15:0] pix);
        return int'({stage, cell_idx, pix});
    endfunction

    function automatic t_calib_result predict_pixel(logic [4:0] cell_idx, logic [15:0] pix,
                                                    logic signed [15:0] adu,
                                                    logic [15:0] gword);
        t_calib_result      res;
        int                 cells_eff;
        int                 key;
        logic               stg;
        logic signed [15:0] off;
        logic signed [15:0] thr;
        int                 thr_i;
        int                 gword_i;
        longint             diff;
        longint             gain_l;
        longint             prod;
        res       = '0;
        cells_eff = (cells_q > CELLS_DEF) ? CELLS_DEF : int'(cells_q);
        diff      = adu;
        // rejected cell: raw sample moved to 4 fractional bits
        if (int'(cell_idx) >= cells_eff) begin
            res.value  = 24'(diff * 16);
            res.status = 1'b1;
            return res;
        end
        // stage pick: unsigned gain word against signed threshold
        stg = 1'b0;
        if (!bypass_q) begin
            key     = int'({cell_idx, pix});
            thr     = thresh_mem.exists(key) ? thresh_mem[key] : '0;
            thr_i   = thr;
            gword_i = gword;
            stg     = (gword_i > thr_i);
        end
        res.stage = stg;
        key       = slot_key(stg, cell_idx, pix);
        if (bad_mem.exists(key) && bad_mem[key]) begin
            res.bad = 1'b1;
            return res;
        end
        off  = offset_mem.exists(key) ? offset_mem[key] : '0;
        diff = diff - off;
        if (bypass_q) begin
            prod = diff * 16;
        end else begin
            gain_l = gain_mem.exists(key) ? gain_mem[key] : '0;
            // Q.12 to Q.4, round half up, floor shift
            prod   = (diff * gain_l + 128) >>> 8;
        end
        if (prod > SAT_HI) prod = SAT_HI;
        if (prod < SAT_LO) prod = SAT_LO;
        res.value = 24'(prod);
        return res;
    endfunction

    task automatic report_error(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("%0t: %s", $time, msg);
    endtask

    // result check, register mirror and request capture on each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bypass_q = 1'b0;
            cells_q  = CELLS_IN_USE_RST;
            awaited_q.delete();
        end else begin
            // result first: a result never belongs to the request taken at this edge
            if (o_valid && !i_stall) begin
                if (awaited_q.size() == 0) begin
                    report_error($sformatf(
                        "unexpected result: value %0d stage %0b mask %0b status %0b",
                        o_corrected_value, o_gain_stage, o_bad_mask, o_status));
                end else begin
                    want = awaited_q.pop_front();
                    if (o_corrected_value !== want.value || o_gain_stage !== want.stage ||
                        o_bad_mask !== want.bad || o_status !== want.status) begin
                        report_error($sformatf(
                            {"result mismatch: expected value %0d stage %0b mask %0b ",
                             "status %0b, got value %0d stage %0b mask %0b status %0b"},
                            want.value, want.stage, want.bad, want.status,
                            o_corrected_value, o_gain_stage, o_bad_mask, o_status));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BYPASS: bypass_q = i_cfg_data[0];
                    CFG_CELLS:  cells_q  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) begin
                if (i_req_type == REQ_LOAD) begin
                    k             = slot_key(i_gain_select, i_cell_req, i_pixel);
                    offset_mem[k] = i_offset_value;
                    gain_mem[k]   = i_rel_gain;
                    bad_mem[k]    = i_bad_flag;
                    if (i_gain_select) thresh_mem[int'({i_cell_req, i_pixel})] = i_threshold_value;
                end else begin
                    awaited_q.push_back(predict_pixel(i_cell_req, i_pixel, i_adu_sample,
                                                      i_gain_word));
                end
            end
        end
        o_pending    = awaited_q.size();
        o_fail_count = mismatches;
    end

endmodule

/* dv/tb_detector_pixel_gain_calibration_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the detector pixel gain calibration unit: request stimulus,
// register phases and result back-pressure; checking lives in dpg_calib_checker.
// Depends on dpg_pkg, the RTL and dpg_calib_checker.
module tb_detector_pixel_gain_calibration_unit;
    import dpg_pkg::*;

    localparam int   ITEM_TARGET  = 1750;
    localparam int   PHASES       = 8;
    localparam int   DRAIN_CYCLES = 12;
    localparam int   HOLD_CYCLES  = 80;
    localparam int   LIMIT_CYCLES = 400000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register index

    typedef struct {
        logic               kind;
        logic [4:0]         cell_idx;
        logic [15:0]        pix;
        logic               stage;
        logic signed [15:0] adu;
        logic [15:0]        gword;
        logic signed [15:0] off;
        logic signed [15:0] thr;
        logic [15:0]        gain;
        logic               bad;
    } t_calib_req;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_req_type;
    logic [4:0]            i_cell_req;
    logic [15:0]           i_pixel;
    logic                  i_gain_select;
    logic signed [15:0]    i_adu_sample;
    logic [15:0]           i_gain_word;
    logic signed [15:0]    i_offset_value;
    logic signed [15:0]    i_threshold_value;
    logic [15:0]           i_rel_gain;
    logic                  i_bad_flag;
    logic                  o_valid;
    logic                  i_stall;
    logic signed [23:0]    o_corrected_value;
    logic                  o_gain_stage;
    logic                  o_bad_mask;
    logic                  o_status;
    int                    mismatch_total;
    int                    results_owed;

    // stimulus bookkeeping: which stages of a {cell, pixel} are loaded
    bit [1:0]           loaded_mask [int];
    logic signed [15:0] stage1_thr  [int];
    int                 ready_q     [$];
    logic [15:0]        pix_pool    [$];
    int                 sent     = 0;
    int                 cycles   = 0;
    bit                 tx_calm  = 1'b0;
    bit                 rx_calm  = 1'b0;
    bit                 hold_out = 1'b0;

    detector_pixel_gain_calibration_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_cell_req        (i_cell_req),
        .i_pixel           (i_pixel),
        .i_gain_select     (i_gain_select),
        .i_adu_sample      (i_adu_sample),
        .i_gain_word       (i_gain_word),
        .i_offset_value    (i_offset_value),
        .i_threshold_value (i_threshold_value),
        .i_rel_gain        (i_rel_gain),
        .i_bad_flag        (i_bad_flag),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_corrected_value (o_corrected_value),
        .o_gain_stage      (o_gain_stage),
        .o_bad_mask        (o_bad_mask),
        .o_status          (o_status)
    );

    dpg_calib_checker calib_chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_req_type        (i_req_type),
        .i_cell_req        (i_cell_req),
        .i_pixel           (i_pixel),
        .i_gain_select     (i_gain_select),
        .i_adu_sample      (i_adu_sample),
        .i_gain_word       (i_gain_word),
        .i_offset_value    (i_offset_value),
        .i_threshold_value (i_threshold_value),
        .i_rel_gain        (i_rel_gain),
        .i_bad_flag        (i_bad_flag),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_corrected_value (o_corrected_value),
        .o_gain_stage      (o_gain_stage),
        .o_bad_mask        (o_bad_mask),
        .o_status          (o_status),
        .o_fail_count      (mismatch_total),
        .o_pending         (results_owed)
    );

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("detector_pixel_gain_calibration_unit regression: fail");
            $finish;
        end
    end

    // result back-pressure: short random stalls, rare long ones, one forced long hold
    initial begin
        int run;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                hold_out = 1'b0;
                i_stall  = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall = 1'b0;
            end else if (rx_calm || $urandom_range(99) < 70) begin
                i_stall = 1'b0;
            end else begin
                run     = ($urandom_range(11) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
                i_stall = 1'b1;
                repeat (run - 1) @(negedge i_clk);
            end
        end
    end

    function automatic t_calib_req rand_req();
        t_calib_req r;
        r.kind     = 1'($urandom);
        r.cell_idx = 5'($urandom);
        r.pix      = 16'($urandom);
        r.stage    = 1'($urandom);
        r.adu      = 16'($urandom);
        r.gword    = 16'($urandom);
        r.off      = 16'($urandom);
        r.thr      = 16'($urandom);
        r.gain     = 16'($urandom);
        r.bad      = 1'($urandom);
        return r;
    endfunction

    function automatic int tx_gap();
        int roll;
        if (tx_calm) return 0;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 93) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // one request transfer; returns at the falling edge after acceptance
    task automatic send_req(t_calib_req r);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type        = r.kind;
        i_cell_req        = r.cell_idx;
        i_pixel           = r.pix;
        i_gain_select     = r.stage;
        i_adu_sample      = r.adu;
        i_gain_word       = r.gword;
        i_offset_value    = r.off;
        i_threshold_value = r.thr;
        i_rel_gain        = r.gain;
        i_bad_flag        = r.bad;
        i_valid           = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic load_entry(logic stage, logic [4:0] cell_idx, logic [15:0] pix,
                              logic signed [15:0] off, logic signed [15:0] thr,
                              logic [15:0] gain, logic bad);
        t_calib_req r;
        int         key;
        bit [1:0]   m;
        r          = rand_req();
        r.kind     = REQ_LOAD;
        r.stage    = stage;
        r.cell_idx = cell_idx;
        r.pix      = pix;
        r.off      = off;
        r.thr      = thr;
        r.gain     = gain;
        r.bad      = bad;
        send_req(r);
        key = int'({cell_idx, pix});
        if (stage) stage1_thr[key] = thr;
        m = loaded_mask.exists(key) ? loaded_mask[key] : 2'b00;
        if (m != 2'b11) begin
            m[stage]         = 1'b1;
            loaded_mask[key] = m;
            if (m == 2'b11) ready_q.push_back(key);
        end
    endtask

    task automatic load_rand(logic stage, logic [4:0] cell_idx, logic [15:0] pix);
        logic [15:0]        gain;
        logic signed [15:0] thr;
        case ($urandom_range(5))
            0:       gain = 16'h0000;
            1:       gain = 16'hFFFF;
            2:       gain = 16'h1000;
            default: gain = 16'($urandom);
        endcase
        // thresholds near zero make the stage pick sensitive to the gain word
        if ($urandom_range(2) == 0) thr = 16'(int'($urandom_range(600)) - 300);
        else                        thr = 16'($urandom);
        load_entry(stage, cell_idx, pix, 16'($urandom), thr, gain,
                   1'($urandom_range(7) == 0));
    endtask

    task automatic pixel_item(logic [4:0] cell_idx, logic [15:0] pix,
                              logic signed [15:0] adu, logic [15:0] gword);
        t_calib_req r;
        r          = rand_req();
        r.kind     = REQ_PIXEL;
        r.cell_idx = cell_idx;
        r.pix      = pix;
        r.adu      = adu;
        r.gword    = gword;
        send_req(r);
    endtask

    // pixel request on a fully loaded entry, gain word often at the threshold edge
    task automatic probe_pixel(int key);
        logic signed [15:0] adu;
        logic [15:0]        gword;
        int                 t;
        t     = stage1_thr[key];
        adu   = 16'($urandom);
        gword = 16'($urandom);
        if ($urandom_range(7) == 0) adu = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        case ($urandom_range(4))
            0: gword = 16'(t);
            1: gword = 16'(t + 1);
            2: gword = 16'(t - 1);
            default: ;
        endcase
        pixel_item(key[20:16], key[15:0], adu, gword);
    endtask

    task automatic wait_idle();
        i_valid = 1'b0;
        while (results_owed != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_step();
        int          roll;
        int          key;
        logic [4:0]  cell_idx;
        logic [15:0] pix;
        logic        first;
        // occasional stretches without idling on either side
        roll = $urandom_range(99);
        if (roll < 5)       tx_calm = !tx_calm;
        else if (roll < 10) rx_calm = !rx_calm;
        roll = $urandom_range(99);
        if (roll < 55) begin
            // load both stages if needed or by chance, then read it back a few times
            cell_idx = 5'($urandom);
            pix      = pix_pool[$urandom_range(pix_pool.size() - 1)];
            key      = int'({cell_idx, pix});
            first    = 1'($urandom);
            if (!(loaded_mask.exists(key) && loaded_mask[key] == 2'b11) ||
                $urandom_range(2) == 0) begin
                load_rand(first, cell_idx, pix);
                load_rand(~first, cell_idx, pix);
            end
            repeat ($urandom_range(4, 1)) probe_pixel(key);
        end else if (roll < 80) begin
            probe_pixel(ready_q[$urandom_range(ready_q.size() - 1)]);
        end else if (roll < 90) begin
            // reload one stage and read right behind it
            key = ready_q[$urandom_range(ready_q.size() - 1)];
            load_rand(1'($urandom), key[20:16], key[15:0]);
            probe_pixel(key);
        end else begin
            // stray single-stage load, mostly off the pixel pool
            load_rand(1'($urandom), 5'($urandom), 16'($urandom));
        end
    endtask

    // main stimulus and verdict
    initial begin
        int bypass_plan [PHASES] = '{0, 1, 0, 1, 0, 0, 1, 0};
        int cells_plan  [PHASES] = '{32, 32, 1, 17, 0, 63, 24, 32};
        int phase_end;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_BYPASS;
        i_cfg_data        = '0;
        i_valid           = 1'b0;
        i_req_type        = REQ_LOAD;
        i_cell_req        = '0;
        i_pixel           = '0;
        i_gain_select     = 1'b0;
        i_adu_sample      = '0;
        i_gain_word       = '0;
        i_offset_value    = '0;
        i_threshold_value = '0;
        i_rel_gain        = '0;
        i_bad_flag        = 1'b0;
        pix_pool = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h8001};
        repeat (19) pix_pool.push_back(16'($urandom));
        cells_plan[6] = $urandom_range(31, 2);
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // clipping both ways, equal-to-threshold and unsigned-above-signed stage picks
        load_entry(1'b0, 5'd0, 16'd0, 16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b0);
        load_entry(1'b1, 5'd0, 16'd0, 16'sh8000, 16'sd100, 16'hFFFF, 1'b0);
        pixel_item(5'd0, 16'd0, 16'sh7FFF, 16'd101);
        pixel_item(5'd0, 16'd0, 16'sh8000, 16'd100);
        pixel_item(5'd0, 16'd0, 16'sd0, 16'hFFFF);
        // most negative threshold with a bad stage 1, then a reload read right behind
        load_entry(1'b0, 5'd31, 16'hFFFF, 16'sd0, 16'sd0, 16'd128, 1'b0);
        load_entry(1'b1, 5'd31, 16'hFFFF, 16'sd0, 16'sh8000, 16'h1000, 1'b1);
        pixel_item(5'd31, 16'hFFFF, 16'sd1, 16'd0);
        load_entry(1'b1, 5'd31, 16'hFFFF, 16'sd0, 16'sh7FFF, 16'h1000, 1'b1);
        // half steps round toward plus infinity, then a bad stage-1 pick
        pixel_item(5'd31, 16'hFFFF, 16'sd1, 16'd0);
        pixel_item(5'd31, 16'hFFFF, -16'sd1, 16'd0);
        pixel_item(5'd31, 16'hFFFF, 16'sd1, 16'h8000);
        // stage-0 load leaves the threshold alone
        load_entry(1'b0, 5'd31, 16'hFFFF, 16'sd5, 16'sh8000, 16'h1000, 1'b0);
        pixel_item(5'd31, 16'hFFFF, 16'sd20, 16'd0);
        // bypass: stage-0 offset only, stage-0 bad flag
        load_entry(1'b0, 5'd2, 16'h0005, 16'sd0, 16'sd0, 16'h1000, 1'b1);
        load_entry(1'b1, 5'd2, 16'h0005, 16'sd0, 16'sd0, 16'h1000, 1'b0);
        write_reg(CFG_BYPASS, 6'd1);
        pixel_item(5'd0, 16'd0, 16'sh8000, 16'hFFFF);
        pixel_item(5'd2, 16'h0005, 16'sd7, 16'hFFFF);
        // rejected cells pass the sample through
        write_reg(CFG_BYPASS, 6'd0);
        write_reg(CFG_CELLS, 6'd1);
        pixel_item(5'd31, 16'hFFFF, 16'sh8000, 16'd0);
        pixel_item(5'd0, 16'd0, 16'sd3, 16'd0);
        write_reg(CFG_CELLS, 6'd0);
        pixel_item(5'd0, 16'd0, 16'sh7FFF, 16'd0);
        // count above the cell total, and a write to an unmapped index
        write_reg(CFG_CELLS, 6'd63);
        write_reg(CFG_SPARE, 6'h3F);
        pixel_item(5'd31, 16'hFFFF, 16'sd20, 16'd0);

        // random phases, one register setting each
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_BYPASS, 6'(bypass_plan[ph]));
            write_reg(CFG_CELLS, 6'(cells_plan[ph]));
            if (ph == 0) begin
                // long receiver hold while requests keep coming, then a full pause
                tx_calm  = 1'b1;
                hold_out = 1'b1;
                repeat (40) probe_pixel(ready_q[$urandom_range(ready_q.size() - 1)]);
                i_valid = 1'b0;
                while (results_owed != 0) @(negedge i_clk);
                tx_calm = 1'b0;
            end
            phase_end = sent + ITEM_TARGET / PHASES;
            while (sent < phase_end) random_step();
        end

        wait_idle();
        if (mismatch_total == 0) begin
            $display("detector_pixel_gain_calibration_unit regression: pass");
        end else begin
            $display("detector_pixel_gain_calibration_unit regression: fail");
        end
        $finish;
    end

endmodule
